// ----- design/qpsk_costas_carrier_loop_macros.svh -----
// Assertion macros for the QPSK Costas carrier loop.
`ifndef QPSK_COSTAS_CARRIER_LOOP_MACROS_SVH
`define QPSK_COSTAS_CARRIER_LOOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define QCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define QCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/qcl_pkg.sv -----
// Constants shared by the QPSK Costas carrier loop.
`timescale 1ns / 1ps
package qcl_pkg;

  localparam int LANES_DEF         = 4;
  localparam int NORM_INTERVAL_DEF = 512;
  localparam int SETTING_REGS      = 4;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_W             = 48;

  localparam int CORDIC_STEPS      = 24;
  localparam int CORDIC_PER_STAGE  = 4;
  localparam int CORDIC_STAGES     = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
  localparam logic signed [26:0] RAD_TO_TURN_Q16 = 27'sd42722830;

  // Arc tangent of 2^-i as a turn fraction, 2^32 = one turn
  localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  // Lane state word: cos, sin, frequency, phase
  localparam int WORD_W = 16 + 16 + 24 + 32;
  localparam logic [WORD_W-1:0] WORD_RESET = {16'h7FFF, 16'h0000, 24'h000000, 32'h0};

endpackage

// ----- design/qcl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module qcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/qpsk_costas_carrier_loop.sv -----
// Top level of the four-lane QPSK Costas carrier-recovery loop.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------------
//  in        sink       in_valid_i / in_stall_o   lane, in_real, in_imag, gain,
//                                                 freq_limit, last_of_block
//  out       source     out_valid_o / out_stall_i out_lane, out_real, out_imag,
//                                                 phase_error, out_last
//  cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// An item runs through a 17-stage pipeline, and its result then enters the output queue.
// Per-lane state lives in one RAM, read at the transfer and written back from the last
// stage, so one lane has a single item in flight and takes no new item until the last one
// is written back. Every NORM_INTERVAL samples on the last lane the pipeline drains and
// LANES phasor rebuilds are issued, one a cycle unless the pipeline is held; transfers
// wait until they are issued. No clearing pass after reset.
// A two-entry output queue lets the pipeline run while one result waits; a full queue
// holds the whole pipeline once a result reaches the last stage.
`timescale 1ns / 1ps
`include "qpsk_costas_carrier_loop_macros.svh"
module qpsk_costas_carrier_loop #(
  parameter int LANES         = qcl_pkg::LANES_DEF,
  parameter int NORM_INTERVAL = qcl_pkg::NORM_INTERVAL_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qcl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qcl_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    lane_i,
  input  logic signed [15:0]            in_real_i,
  input  logic signed [15:0]            in_imag_i,
  input  logic [15:0]                   gain_i,
  input  logic [22:0]                   freq_limit_i,
  input  logic                          last_of_block_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    out_lane_o,
  output logic signed [15:0]            out_real_o,
  output logic signed [15:0]            out_imag_o,
  output logic signed [16:0]            phase_error_o,
  output logic                          out_last_o
);
  import qcl_pkg::*;

  localparam int LW   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CW   = $clog2(NORM_INTERVAL);
  localparam int NSTG = 17;
  localparam int CS0  = 9;   // first CORDIC stage

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_DRAIN = 3'b010,
    ST_NORM  = 3'b100
  } seq_e;

  typedef struct packed {
    logic               norm;
    logic [LW-1:0]      lane;
    logic [1:0]         lane_in;
    logic               last;
    logic [15:0]        alpha;
    logic [15:0]        beta;
    logic [15:0]        clip;
    logic [22:0]        lim;
    logic signed [20:0] xr;
    logic signed [20:0] xi;
    logic signed [15:0] cosv;
    logic signed [15:0] sinv;
    logic signed [23:0] freq;
    logic [31:0]        phase;
    logic signed [37:0] pre;
    logic signed [37:0] pim;
    logic signed [15:0] ore;
    logic signed [15:0] oim;
    logic signed [16:0] err;
    logic signed [33:0] bp;
    logic signed [33:0] ap;
    logic signed [23:0] ra;
    logic signed [23:0] d;
    logic signed [50:0] prod;
    logic [1:0]         quad;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [15:0] dc;
    logic signed [15:0] ds;
    logic signed [32:0] mc;
    logic signed [32:0] ms;
  } pipe_t;

  typedef struct packed {
    logic [1:0]         lane_in;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic signed [16:0] err;
    logic               last;
  } res_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7FFF;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7FFFFF;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic [LW-1:0] lane_fold(input logic [1:0] l);
    logic [4:0] v;
    v = {3'b000, l};
    for (int k = 0; k < 4; k++) begin
      if (v >= 5'(LANES)) v = v - 5'(LANES);
    end
    return LW'(v);
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [CFG_W-1:0] cfg_q [SETTING_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SETTING_REGS; r++) cfg_q[r] <= '0;
    end else if (cfg_we_i) begin
      for (int r = 0; r < SETTING_REGS; r++) begin
        // drop writes to registers beyond the lane count
        if (int'(cfg_index_i) == r && r < LANES) cfg_q[r] <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------- control
  seq_e            st_q, st_d;
  logic [LANES-1:0] busy_q, busy_d;
  logic [LW-1:0]   nidx_q, nidx_d;
  logic [CW-1:0]   ncnt_q, ncnt_d;
  logic            v_q [NSTG];
  pipe_t           pq [NSTG];
  pipe_t           pd [NSTG];
  logic [1:0]      ocnt_q, ocnt_d;
  logic            orp_q, owp_q;
  res_t            ofifo_q [2];

  logic            en, acc, norm_iss, issue, wb, push, pop;
  logic [LW-1:0]   in_lane, iss_lane, wb_lane;
  logic [CFG_W-1:0] lane_cfg;

  assign en       = !(v_q[NSTG-1] && ocnt_q == 2'd2);
  assign in_lane  = lane_fold(lane_i);
  assign acc      = in_valid_i && !in_stall_o;
  assign norm_iss = en && st_q == ST_NORM;
  assign issue    = acc || norm_iss;
  assign iss_lane = (st_q == ST_NORM) ? nidx_q : in_lane;
  assign wb       = en && v_q[NSTG-1];
  assign wb_lane  = pq[NSTG-1].lane;
  assign push     = wb && !pq[NSTG-1].norm;
  assign pop      = out_valid_o && !out_stall_i;

  // Hold the input while the pipeline is frozen, a rebuild is due or the lane is in flight
  assign in_stall_o = !(en && st_q == ST_RUN && !busy_q[in_lane]);

  always_comb begin
    lane_cfg = '0;
    for (int r = 0; r < SETTING_REGS; r++) begin
      if (int'(in_lane) == r) lane_cfg = cfg_q[r];
    end
  end

  always_comb begin
    st_d   = st_q;
    nidx_d = nidx_q;
    ncnt_d = ncnt_q;
    busy_d = busy_q;
    if (wb) busy_d[wb_lane] = 1'b0;
    if (issue) busy_d[iss_lane] = 1'b1;
    unique case (st_q)
      ST_RUN: begin
        if (acc && in_lane == LW'(LANES - 1)) begin
          if (ncnt_q == CW'(NORM_INTERVAL - 1)) begin
            ncnt_d = '0;
            st_d   = ST_DRAIN;
          end else begin
            ncnt_d = ncnt_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (busy_q == '0) begin
          nidx_d = '0;
          st_d   = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_iss) begin
          nidx_d = nidx_q + 1'b1;
          if (nidx_q == LW'(LANES - 1)) st_d = ST_RUN;
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_RUN;
      nidx_q <= '0;
      ncnt_q <= '0;
      busy_q <= '0;
    end else begin
      st_q   <= st_d;
      nidx_q <= nidx_d;
      ncnt_q <= ncnt_d;
      busy_q <= busy_d;
    end
  end

  // ---------------------------------------------------------------- state RAM
  logic [WORD_W-1:0] ram_rdata, ram_wdata, rd_word;
  logic [LANES-1:0]  written_q;
  logic              rd_vld_q;
  logic signed [15:0] wb_cos, wb_sin;

  qcl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LANES),
    .AW    (LW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wb),
    .waddr_i (wb_lane),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (iss_lane),
    .rdata_o (ram_rdata)
  );

  // An entry never written reads as its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wb) written_q[wb_lane] <= 1'b1;
      if (issue) rd_vld_q <= written_q[iss_lane];
    end
  end

  assign rd_word = rd_vld_q ? ram_rdata : WORD_RESET;

  // ---------------------------------------------------------------- datapath
  always_comb begin
    logic signed [47:0] t0, t1, t2, lim_s;
    logic signed [31:0] x, y, z;
    logic signed [31:0] sx, sy;
    logic [31:0]        turn;
    int                 si;

    pd[0] = pq[0];
    pd[0].norm    = norm_iss;
    pd[0].lane    = iss_lane;
    pd[0].lane_in = lane_i;
    pd[0].last    = last_of_block_i;
    pd[0].alpha   = lane_cfg[15:0];
    pd[0].beta    = lane_cfg[31:16];
    pd[0].clip    = lane_cfg[47:32];
    pd[0].lim     = freq_limit_i;
    t0 = 48'(in_real_i * $signed({1'b0, gain_i}));
    t1 = 48'(in_imag_i * $signed({1'b0, gain_i}));
    pd[0].xr = 21'((t0 + 48'sd2048) >>> 12);
    pd[0].xi = 21'((t1 + 48'sd2048) >>> 12);

    for (int k = 1; k < NSTG; k++) pd[k] = pq[k-1];

    // derotation products
    pd[1].cosv  = rd_word[87:72];
    pd[1].sinv  = rd_word[71:56];
    pd[1].freq  = rd_word[55:32];
    pd[1].phase = rd_word[31:0];
    t0 = 48'(pq[0].xr * $signed(rd_word[87:72]));
    t1 = 48'(pq[0].xi * $signed(rd_word[71:56]));
    pd[1].pre = 38'(t0 + t1);
    t0 = 48'(pq[0].xi * $signed(rd_word[87:72]));
    t1 = 48'(pq[0].xr * $signed(rd_word[71:56]));
    pd[1].pim = 38'(t0 - t1);

    pd[2].ore = sat16((48'(pq[1].pre) + 48'sd16384) >>> 15);
    pd[2].oim = sat16((48'(pq[1].pim) + 48'sd16384) >>> 15);

    // sign-decision detector, clip
    t0 = (pq[2].ore >= 0) ? 48'(pq[2].oim) : -48'(pq[2].oim);
    t1 = (pq[2].oim >= 0) ? 48'(pq[2].ore) : -48'(pq[2].ore);
    t2 = t0 - t1;
    if (pq[2].clip != '0) begin
      lim_s = 48'({pq[2].clip, 1'b0});
      if (t2 > lim_s) t2 = lim_s;
      if (t2 < -lim_s) t2 = -lim_s;
    end
    if (t2 > 48'sd65535) t2 = 48'sd65535;
    if (t2 < -48'sd65536) t2 = -48'sd65536;
    pd[3].err = 17'(t2);

    pd[4].bp = 34'($signed({1'b0, pq[3].beta}) * pq[3].err);
    pd[4].ap = 34'($signed({1'b0, pq[3].alpha}) * pq[3].err);

    // frequency integrator
    t0 = (48'(pq[4].bp) + 48'sd1024) >>> 11;
    t1 = 48'(pq[4].freq) + t0;
    if (pq[4].lim != '0) begin
      lim_s = 48'({1'b0, pq[4].lim});
      if (t1 > lim_s) t1 = lim_s;
      if (t1 < -lim_s) t1 = -lim_s;
    end
    if (!pq[4].norm) pd[5].freq = sat24(t1);
    pd[5].ra = 24'((48'(pq[4].ap) + 48'sd1024) >>> 11);

    pd[6].d = sat24(48'(pq[5].freq) + 48'(pq[5].ra));

    pd[7].prod = 51'(pq[6].d * RAD_TO_TURN_Q16);

    // step angle in turns; a rebuild takes the stored phase instead
    turn = pq[7].norm ? pq[7].phase : pq[7].prod[47:16];
    if (!pq[7].norm) pd[8].phase = pq[7].phase + turn;
    pd[8].quad = turn[31:30];
    pd[8].cx   = CORDIC_X0;
    pd[8].cy   = '0;
    pd[8].cz   = $signed({2'b00, turn[29:0]});

    for (int s = 0; s < CORDIC_STAGES; s++) begin
      x = pq[CS0-1+s].cx;
      y = pq[CS0-1+s].cy;
      z = pq[CS0-1+s].cz;
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        si = s * CORDIC_PER_STAGE + j;
        sx = x >>> si;
        sy = y >>> si;
        if (z >= 0) begin
          x = x - sy;
          y = y + sx;
          z = z - ATAN_TURN[si];
        end else begin
          x = x + sy;
          y = y - sx;
          z = z + ATAN_TURN[si];
        end
      end
      pd[CS0+s].cx = x;
      pd[CS0+s].cy = y;
      pd[CS0+s].cz = z;
    end

    // quadrant fold-back
    case (pq[14].quad)
      2'd0:    begin t0 = 48'(pq[14].cx);  t1 = 48'(pq[14].cy);  end
      2'd1:    begin t0 = -48'(pq[14].cy); t1 = 48'(pq[14].cx);  end
      2'd2:    begin t0 = -48'(pq[14].cx); t1 = -48'(pq[14].cy); end
      default: begin t0 = 48'(pq[14].cy);  t1 = -48'(pq[14].cx); end
    endcase
    pd[15].dc = sat16((t0 + 48'sd16384) >>> 15);
    pd[15].ds = sat16((t1 + 48'sd16384) >>> 15);

    // phasor rotation products
    pd[16].mc = 33'(48'(pq[15].cosv * pq[15].dc) - 48'(pq[15].sinv * pq[15].ds));
    pd[16].ms = 33'(48'(pq[15].sinv * pq[15].dc) + 48'(pq[15].cosv * pq[15].ds));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NSTG; k++) pq[k] <= pd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= issue;
      for (int k = 1; k < NSTG; k++) v_q[k] <= v_q[k-1];
    end
  end

  // Write back: a rebuild replaces the phasor by the CORDIC output
  assign wb_cos = pq[NSTG-1].norm ? pq[NSTG-1].dc
                                  : sat16((48'(pq[NSTG-1].mc) + 48'sd16384) >>> 15);
  assign wb_sin = pq[NSTG-1].norm ? pq[NSTG-1].ds
                                  : sat16((48'(pq[NSTG-1].ms) + 48'sd16384) >>> 15);
  assign ram_wdata = {wb_cos, wb_sin, pq[NSTG-1].freq, pq[NSTG-1].phase};

  // ---------------------------------------------------------------- output queue
  always_comb begin
    ocnt_d = ocnt_q;
    if (push && !pop) ocnt_d = ocnt_q + 1'b1;
    if (pop && !push) ocnt_d = ocnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      orp_q  <= 1'b0;
      owp_q  <= 1'b0;
    end else begin
      ocnt_q <= ocnt_d;
      if (push) owp_q <= !owp_q;
      if (pop) orp_q <= !orp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ofifo_q[owp_q] <= '{lane_in: pq[NSTG-1].lane_in, re: pq[NSTG-1].ore,
                          im: pq[NSTG-1].oim, err: pq[NSTG-1].err,
                          last: pq[NSTG-1].last};
    end
  end

  assign out_valid_o   = ocnt_q != 2'd0;
  assign out_lane_o    = ofifo_q[orp_q].lane_in;
  assign out_real_o    = ofifo_q[orp_q].re;
  assign out_imag_o    = ofifo_q[orp_q].im;
  assign phase_error_o = ofifo_q[orp_q].err;
  assign out_last_o    = ofifo_q[orp_q].last;

  // ---------------------------------------------------------------- assertions
  `QCL_ASSERT_NOW(a_issue_idle_lane, issue, !busy_q[iss_lane], "issue to a lane in flight")
  `QCL_ASSERT_NOW(a_wb_busy_lane, wb, busy_q[wb_lane], "write-back to an idle lane")
  `QCL_ASSERT_NOW(a_push_has_room, push, ocnt_q != 2'd2, "result pushed into a full queue")
  `QCL_ASSERT_NEXT(a_drain_blocks, st_q == ST_DRAIN && busy_q != '0, !acc || st_q == ST_RUN,
                   "transfer taken while draining")

endmodule

// ----- sim/tb_qpsk_costas_carrier_loop.sv -----
// Self-checking testbench for the four-lane QPSK Costas carrier-recovery loop.
`timescale 1ns / 1ps
module tb_qpsk_costas_carrier_loop;

  localparam int NLANES      = qcl_pkg::LANES_DEF;
  localparam int NORM_SPAN   = qcl_pkg::NORM_INTERVAL_DEF;
  localparam int DRAIN_WAIT  = 40;      // covers the pipeline depth plus the phasor rebuild slots
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]         lane;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [15:0]        gain;
    logic [22:0]        freq_limit;
    logic               last;
  } costas_sample_t;

  typedef struct packed {
    logic [1:0]         lane;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic signed [16:0] err;
    logic               last;
  } derotated_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [qcl_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [qcl_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] lane_i = '0;
  logic signed [15:0] in_real_i = '0;
  logic signed [15:0] in_imag_i = '0;
  logic [15:0] gain_i = '0;
  logic [22:0] freq_limit_i = '0;
  logic last_of_block_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] out_lane_o;
  logic signed [15:0] out_real_o;
  logic signed [15:0] out_imag_o;
  logic signed [16:0] phase_error_o;
  logic out_last_o;

  qpsk_costas_carrier_loop u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .lane_i, .in_real_i, .in_imag_i, .gain_i,
    .freq_limit_i, .last_of_block_i,
    .out_valid_o, .out_stall_i, .out_lane_o, .out_real_o, .out_imag_o,
    .phase_error_o, .out_last_o
  );

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Loop state mirrored per lane
  logic [47:0] loop_settings [NLANES];
  longint      phasor_re [NLANES];
  longint      phasor_im [NLANES];
  longint      freq_acc [NLANES];
  logic [31:0] phase_turns [NLANES];
  int          norm_tally;

  derotated_t pending_results [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;       // stretches where neither side idles
  int         lane_rr = 0;

  function automatic longint sat_range(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Add half an LSB, then shift right arithmetically
  function automatic longint round_shift(input longint v, input int n);
    longint half;
    half = longint'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  // Sine and cosine of a turn fraction by rotation on the first quadrant
  function automatic void turn_sincos(input logic [31:0] turn, output longint c,
                                      output longint s);
    longint x, y, z, xs, ys, cx, sy;
    x = longint'(qcl_pkg::CORDIC_X0);
    y = 0;
    z = longint'({34'b0, turn[29:0]});
    for (int i = 0; i < qcl_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(qcl_pkg::ATAN_TURN[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(qcl_pkg::ATAN_TURN[i]);
      end
    end
    case (turn[31:30])
      2'd0: begin cx = x;  sy = y;  end
      2'd1: begin cx = -y; sy = x;  end
      2'd2: begin cx = -x; sy = -y; end
      default: begin cx = y; sy = -x; end
    endcase
    c = sat_range(round_shift(cx, 15), -32768, 32767);
    s = sat_range(round_shift(sy, 15), -32768, 32767);
  endfunction

  function automatic void reset_loop_state();
    for (int l = 0; l < NLANES; l++) begin
      loop_settings[l] = '0;
      phasor_re[l] = 32767;
      phasor_im[l] = 0;
      freq_acc[l] = 0;
      phase_turns[l] = '0;
    end
    norm_tally = 0;
  endfunction

  // Derotate one sample, run the detector and advance the lane's loop
  function automatic derotated_t derotate_and_track(input costas_sample_t it);
    derotated_t r;
    int l;
    longint alpha, beta, clip, lim, g, xr, xi, c, s, ore, oim, err, f, d, dc, ds, t;
    logic [31:0] turn;
    l = it.lane;
    alpha = longint'({48'b0, loop_settings[l][15:0]});
    beta = longint'({48'b0, loop_settings[l][31:16]});
    clip = longint'({48'b0, loop_settings[l][47:32]});
    lim = longint'({41'b0, it.freq_limit});
    g = longint'({48'b0, it.gain});
    xr = round_shift(longint'(it.re) * g, 12);
    xi = round_shift(longint'(it.im) * g, 12);
    c = phasor_re[l];
    s = phasor_im[l];
    ore = sat_range(round_shift(xr * c + xi * s, 15), -32768, 32767);
    oim = sat_range(round_shift(xi * c - xr * s, 15), -32768, 32767);
    err = (ore >= 0 ? oim : -oim) - (oim >= 0 ? ore : -ore);
    if (clip != 0) err = sat_range(err, -2 * clip, 2 * clip);
    err = sat_range(err, -65536, 65535);
    f = freq_acc[l] + round_shift(beta * err, 11);
    if (lim != 0) f = sat_range(f, -lim, lim);
    f = sat_range(f, -8388608, 8388607);
    freq_acc[l] = f;
    d = sat_range(f + round_shift(alpha * err, 11), -8388608, 8388607);
    t = (d * longint'(qcl_pkg::RAD_TO_TURN_Q16)) >>> 16;
    turn = t[31:0];
    turn_sincos(turn, dc, ds);
    phasor_re[l] = sat_range(round_shift(c * dc - s * ds, 15), -32768, 32767);
    phasor_im[l] = sat_range(round_shift(s * dc + c * ds, 15), -32768, 32767);
    phase_turns[l] = phase_turns[l] + turn;
    if (l == NLANES - 1) begin
      norm_tally++;
      // Rebuild every phasor at unit magnitude from its accumulated phase
      if (norm_tally >= NORM_SPAN) begin
        norm_tally = 0;
        for (int k = 0; k < NLANES; k++) turn_sincos(phase_turns[k], phasor_re[k], phasor_im[k]);
      end
    end
    r.lane = it.lane;
    r.re = ore[15:0];
    r.im = oim[15:0];
    r.err = err[16:0];
    r.last = it.last;
    return r;
  endfunction

  // Cycle counter, calm stretches and the run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) calm <= ($urandom_range(3) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stall: mostly short, sometimes long
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else if (calm) begin
      out_stall_i = 1'b0;
    end else begin
      int r;
      r = $urandom_range(99);
      out_stall_i = 1'b0;
      if (r >= 92) stall_left = $urandom_range(40, 10);
      else if (r >= 65) stall_left = $urandom_range(3, 1);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: lane %0d", out_lane_o);
        fail_count++;
      end else begin
        derotated_t e;
        e = pending_results.pop_front();
        if (out_lane_o !== e.lane) begin
          $error("out_lane: expected %0d, got %0d", e.lane, out_lane_o); fail_count++;
        end
        if (out_real_o !== e.re) begin
          $error("out_real: expected %0d, got %0d", e.re, out_real_o); fail_count++;
        end
        if (out_imag_o !== e.im) begin
          $error("out_imag: expected %0d, got %0d", e.im, out_imag_o); fail_count++;
        end
        if (phase_error_o !== e.err) begin
          $error("phase_error: expected %0d, got %0d", e.err, phase_error_o); fail_count++;
        end
        if (out_last_o !== e.last) begin
          $error("out_last: expected %0d, got %0d", e.last, out_last_o); fail_count++;
        end
      end
    end
  end

  // Drive one sample after a random gap and hold it until the transfer
  task automatic send_sample(input costas_sample_t it);
    int gap, r;
    r = $urandom_range(99);
    gap = 0;
    if (!calm) begin
      if (r >= 95) gap = $urandom_range(40, 10);
      else if (r >= 70) gap = $urandom_range(3, 1);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    lane_i = it.lane;
    in_real_i = it.re;
    in_imag_i = it.im;
    gain_i = it.gain;
    freq_limit_i = it.freq_limit;
    last_of_block_i = it.last;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_results.push_back(derotate_and_track(it));
  endtask

  // Hold until every result is back and the pipeline has emptied
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_lane_settings(input int idx, input logic [47:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx[qcl_pkg::CFG_IDX_W-1:0];
    cfg_data_i = value;
    @(posedge clk_i);
    loop_settings[idx] = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic costas_sample_t random_sample(input int lane);
    costas_sample_t it;
    it.lane = lane[1:0];
    it.re = pick16();
    it.im = pick16();
    // Gain around unity mostly, extremes sometimes
    case ($urandom_range(4))
      0: it.gain = pick16();
      default: it.gain = 16'($urandom_range(8191, 1024));
    endcase
    case ($urandom_range(4))
      0: it.freq_limit = '0;
      1: it.freq_limit = 23'h7FFFFF;
      2: it.freq_limit = 23'($urandom_range(4095));
      default: it.freq_limit = 23'($urandom);
    endcase
    it.last = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic logic [47:0] random_settings();
    return {pick16(), pick16(), pick16()};
  endfunction

  // Extreme field values spread over the lanes, then tiny inputs, with reset settings then full-scale ones
  task automatic test_directed_extremes();
    costas_sample_t it;
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) for (int l = 0; l < NLANES; l++) write_lane_settings(l, 48'hFFFF_FFFF_FFFF);
      for (int l = 0; l < NLANES; l++) begin
        it.lane = l[1:0];
        it.re = (l[0]) ? 16'sh8000 : 16'sh7FFF;
        it.im = (l[1]) ? 16'sh7FFF : 16'sh8000;
        it.gain = (l == 0) ? 16'h0000 : 16'hFFFF;
        it.freq_limit = (l[0]) ? 23'h7FFFFF : 23'h0;
        it.last = l[0];
        send_sample(it);
      end
      for (int l = 0; l < NLANES; l++) begin
        it = '0;
        it.lane = l[1:0];
        it.gain = 16'h1000;
        it.re = (l == 2) ? 16'sh0000 : -16'sd1;
        it.freq_limit = 23'd1;
        it.last = ~l[0];
        send_sample(it);
      end
    end
  endtask

  // Random samples in lane order, fresh settings per phase, occasional stray lanes
  task automatic test_random_tracking(input int phases, input int per_phase);
    int lane;
    for (int p = 0; p < phases; p++) begin
      for (int l = 0; l < NLANES; l++) begin
        case (p % 4)
          0: write_lane_settings(l, {16'h2000, 16'h0040, 16'h0800});
          1: write_lane_settings(l, 48'h0);
          default: write_lane_settings(l, random_settings());
        endcase
      end
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(19) == 0) begin
          lane = $urandom_range(NLANES - 1);
        end else begin
          lane = lane_rr;
          lane_rr = (lane_rr + 1) % NLANES;
        end
        send_sample(random_sample(lane));
        // Hold off until everything has drained, once
        if (p == 1 && n == per_phase / 2) wait_drained();
      end
    end
  endtask

  // Drive mostly the last lane, NORM_SPAN + 20 samples in all, toward a renormalisation
  task automatic test_renormalisation();
    int lane;
    write_lane_settings(NLANES - 1, {16'h4000, 16'h0200, 16'h1800});
    write_lane_settings(0, {16'h0000, 16'h0100, 16'h3000});
    for (int n = 0; n < NORM_SPAN + 20; n++) begin
      lane = ($urandom_range(7) == 0) ? $urandom_range(NLANES - 2) : NLANES - 1;
      send_sample(random_sample(lane));
    end
  endtask

  initial begin
    reset_loop_state();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_extremes();
    test_random_tracking(6, 90);
    test_renormalisation();
    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
